### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the date adder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Checks that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond)) else $error(msg);

`endif

### design/gdad_pkg.sv
// ----------------------------------------------------------------------------
// gdad_pkg
// Types, constants and calendar functions shared by the date adder modules.
// ----------------------------------------------------------------------------
package gdad_pkg;

    // Field widths of the items.
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int ADD_W   = 16;
    // The running day count holds a start day plus the full count to add.
    localparam int K_W     = ADD_W + 1;

    // Queue depth between the front and the walk; must be a power of two.
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Month codes.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Month lengths.
    localparam logic [DAY_W-1:0] LEN_28 = 5'd28;
    localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
    localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
    localparam logic [DAY_W-1:0] LEN_31 = 5'd31;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 16'hFFFF;

    // A year is a multiple of 25 exactly when its product with the inverse
    // of 25 modulo 2^16 does not exceed floor((2^16 - 1) / 25).
    localparam logic [YEAR_W-1:0] INV_25    = 16'd23593;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

    // One item as it travels from the front to the walk.
    typedef struct packed {
        logic [K_W-1:0]     k;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_item;

    // Queue status seen by the front and the walk.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    // Leap year: a multiple of 4, except centuries that are not multiples
    // of 400. With the year a multiple of 4, it is a century when it is
    // also a multiple of 25, and a multiple of 400 when also one of 16.
    function automatic logic gdad_is_leap(input logic [YEAR_W-1:0] year);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = year * INV_25;
        div25 = (prod <= DIV25_MAX);
        return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
    endfunction

    // Length of a month, with the leap flag of its year.
    function automatic logic [DAY_W-1:0] gdad_month_len(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        case (month)
            MONTH_FEB: len = leap ? LEN_29 : LEN_28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
            default: len = LEN_31;
        endcase
        return len;
    endfunction

endpackage

### design/gregorian_date_add_days_top.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days_top
// Adds a count of days to a Gregorian date by walking month by month.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  input     i_valid / o_stall   i_start_day, i_start_month, i_start_year,
//                                i_days_to_add
//  output    o_valid / i_stall   o_end_day, o_end_month, o_end_year,
//                                o_year_overflow
//
//  An item passes the input stage register, the queue, the walk's prep and
//  walk states and the result register; the walk subtracts one month
//  length per cycle, up to about 2160 months for the largest count.
//  The input stage and a two-entry queue keep taking items while a walk runs.
//  Reset is synchronous and active low; it empties the queue and the walk.
//  A stalled result holds the walk of the next item at its last month.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [gdad_pkg::DAY_W-1:0]   i_start_day,
    input  logic [gdad_pkg::MONTH_W-1:0] i_start_month,
    input  logic [gdad_pkg::YEAR_W-1:0]  i_start_year,
    input  logic [gdad_pkg::ADD_W-1:0]   i_days_to_add,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [gdad_pkg::DAY_W-1:0]   o_end_day,
    output logic [gdad_pkg::MONTH_W-1:0] o_end_month,
    output logic [gdad_pkg::YEAR_W-1:0]  o_end_year,
    output logic                         o_year_overflow
);
    import gdad_pkg::*;

    t_fifo_status fifo_status;
    t_item        push_item;
    t_item        pop_item;
    logic         push;
    logic         pop;

    // Input stage.
    gdad_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_start_day   (i_start_day),
        .i_start_month (i_start_month),
        .i_start_year  (i_start_year),
        .i_days_to_add (i_days_to_add),
        .i_fifo_status (fifo_status),
        .o_push        (push),
        .o_item        (push_item)
    );

    // Queue between the input stage and the walk.
    gdad_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (pop_item),
        .o_status (fifo_status)
    );

    // Month walk and result register.
    gdad_walk u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fifo_status   (fifo_status),
        .i_item          (pop_item),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_end_day       (o_end_day),
        .o_end_month     (o_end_month),
        .o_end_year      (o_end_year),
        .o_year_overflow (o_year_overflow)
    );

endmodule

### design/gdad_front.sv
// ----------------------------------------------------------------------------
// gdad_front
// Input stage: takes an item, clamps the month and forms the day count.
// ----------------------------------------------------------------------------
module gdad_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [gdad_pkg::DAY_W-1:0]   i_start_day,
    input  logic [gdad_pkg::MONTH_W-1:0] i_start_month,
    input  logic [gdad_pkg::YEAR_W-1:0]  i_start_year,
    input  logic [gdad_pkg::ADD_W-1:0]   i_days_to_add,
    input  gdad_pkg::t_fifo_status       i_fifo_status,
    output logic                         o_push,
    output gdad_pkg::t_item              o_item
);
    import gdad_pkg::*;

    logic       r_valid;
    t_item      r_item;
    logic       accept;
    logic [MONTH_W-1:0] month_fix;

    // The stage holds one item; it stalls only while that item cannot move.
    assign o_stall = r_valid && i_fifo_status.full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_fifo_status.full;
    assign o_item  = r_item;

    // Month zero counts as January, months past twelve as December.
    always_comb begin
        month_fix = i_start_month;
        if (i_start_month == '0) begin
            month_fix = MONTH_JAN;
        end else if (i_start_month inside {[4'd13:4'd15]}) begin
            month_fix = MONTH_DEC;
        end
    end

    // Valid flag of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Payload of the stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.k     <= K_W'(i_start_day) + K_W'(i_days_to_add);
            r_item.month <= month_fix;
            r_item.year  <= i_start_year;
        end
    end

endmodule

### design/gdad_fifo.sv
// ----------------------------------------------------------------------------
// gdad_fifo
// Short queue that decouples the input stage from the month walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdad_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  gdad_pkg::t_item        i_item,
    input  logic                   i_pop,
    output gdad_pkg::t_item        o_item,
    output gdad_pkg::t_fifo_status o_status
);
    import gdad_pkg::*;

    t_item            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `ASSERT_IMPLY(a_no_push_full, i_push, !o_status.full, "push into a full queue")
    `ASSERT_IMPLY(a_no_pop_empty, i_pop, !o_status.empty, "pop from an empty queue")
    `ASSERT_ALWAYS(a_count_range, r_count <= CNT_W'(FIFO_DEPTH), "queue count out of range")

endmodule

### design/gdad_walk.sv
// ----------------------------------------------------------------------------
// gdad_walk
// Month walk: subtracts one month length per cycle and holds the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdad_walk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gdad_pkg::t_fifo_status        i_fifo_status,
    input  gdad_pkg::t_item               i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gdad_pkg::DAY_W-1:0]    o_end_day,
    output logic [gdad_pkg::MONTH_W-1:0]  o_end_month,
    output logic [gdad_pkg::YEAR_W-1:0]   o_end_year,
    output logic                          o_year_overflow
);
    import gdad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PREP = 3'b010,
        S_WALK = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [K_W-1:0]     r_k;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year;
    logic               r_leap;
    logic               r_out_valid;
    logic [DAY_W-1:0]   r_end_day;
    logic [MONTH_W-1:0] r_end_month;
    logic [YEAR_W-1:0]  r_end_year;
    logic               r_end_ovf;

    logic [DAY_W-1:0]   len;
    logic               fits;
    logic               wrap_ovf;
    logic               out_free;
    logic               finish;

    // Current month length; the leap flag is registered from the year and
    // follows it in the next cycle, which is always before February is reached.
    assign len      = gdad_month_len(r_month, r_leap);
    assign fits     = (r_k <= K_W'(len));
    assign wrap_ovf = !fits && (r_month == MONTH_DEC) && (r_year == YEAR_MAX);
    assign out_free = !r_out_valid || !i_stall;
    assign finish   = (r_state == S_WALK) && (fits || wrap_ovf) && out_free;
    assign o_pop    = (r_state == S_IDLE) && !i_fifo_status.empty;

    assign o_valid         = r_out_valid;
    assign o_end_day       = r_end_day;
    assign o_end_month     = r_end_month;
    assign o_end_year      = r_end_year;
    assign o_year_overflow = r_end_ovf;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: n_state = S_WALK;
            S_WALK: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk registers: load from the queue, then one month per cycle.
    always_ff @(posedge i_clk) begin
        r_leap <= gdad_is_leap(r_year);
        if (o_pop) begin
            r_k     <= i_item.k;
            r_month <= i_item.month;
            r_year  <= i_item.year;
        end else if ((r_state == S_WALK) && !fits && !wrap_ovf) begin
            r_k <= r_k - K_W'(len);
            if (r_month == MONTH_DEC) begin
                r_month <= MONTH_JAN;
                r_year  <= r_year + 1'b1;
            end else begin
                r_month <= r_month + 1'b1;
            end
        end
    end

    // Result register; an overflow gives the last date of the last year.
    always_ff @(posedge i_clk) begin
        if (finish) begin
            if (wrap_ovf) begin
                r_end_day   <= LEN_31;
                r_end_month <= MONTH_DEC;
                r_end_year  <= YEAR_MAX;
                r_end_ovf   <= 1'b1;
            end else begin
                r_end_day   <= r_k[DAY_W-1:0];
                r_end_month <= r_month;
                r_end_year  <= r_year;
                r_end_ovf   <= 1'b0;
            end
        end
    end

    `ASSERT_IMPLY(a_walk_month, r_state == S_WALK, (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC), "walk month out of range")
    `ASSERT_IMPLY(a_ovf_max_date, r_out_valid && r_end_ovf, (r_end_day == LEN_31) && (r_end_month == MONTH_DEC) && (r_end_year == YEAR_MAX), "overflow without the maximum date")
    `ASSERT_NEXT(a_finish_valid, finish, r_out_valid && (r_state == S_IDLE), "finished walk gave no result")

endmodule
